/* rtl/psrl_pkg.sv */
// Package for the per-source rate limit table: entry layout, codes, defaults, time helper.
package psrl_pkg;

    // Table geometry and register defaults
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int BAN_FACTOR      = 2;

    localparam logic [15:0] DEF_WINDOW_SECS = 16'd10;
    localparam logic [15:0] DEF_RATE_LIMIT  = 16'd20;
    localparam logic [31:0] DEF_STALE_SECS  = 32'd300;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STALE  = 2'd2;

    // Item kinds
    localparam logic KIND_CONN  = 1'b0;
    localparam logic KIND_SWEEP = 1'b1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [6:0]  FREED_MAX = 7'h7F;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] conn_time;
        logic [31:0] last_reject;
        logic [15:0] count;
        logic        blocked;
    } entry_t;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] limit;
        logic [31:0] stale;
    } cfg_t;

    // Results of the per-entry update logic
    typedef struct packed {
        entry_t sweep_ent;
        logic   sweep_freed;
        entry_t conn_ent;
        logic   conn_write;
        logic   conn_reject;
    } upd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    // now - then as a signed 33-bit value
    function automatic logic signed [32:0] elapsed(input logic [31:0] now,
                                                   input logic [31:0] then);
        elapsed = $signed({1'b0, now}) - $signed({1'b0, then});
    endfunction

endpackage

/* rtl/psrl_entry_update.sv */
// Per-entry update logic: connection hit outcome and sweep outcome for one table word.
module psrl_entry_update
    import psrl_pkg::*;
(
    input  entry_t      ent,
    input  logic [31:0] now,
    input  cfg_t        cfg,
    output upd_t        upd
);

    logic [17:0]        ban_len;
    logic signed [32:0] d_conn;
    logic signed [32:0] d_rej;
    logic               ban_over;
    logic               in_window;
    logic               stale;
    logic [15:0]        cnt0;
    logic [15:0]        cnt1;
    logic               sweep_blk;

    assign ban_len   = 18'(BAN_FACTOR) * {2'b00, cfg.window};
    assign d_conn    = elapsed(now, ent.conn_time);
    assign d_rej     = elapsed(now, ent.last_reject);
    assign ban_over  = d_rej > $signed({15'd0, ban_len});
    assign in_window = d_conn < $signed({17'd0, cfg.window});
    assign stale     = d_conn > $signed({1'b0, cfg.stale});

    // An expired ban clears the count before the window check
    assign cnt0 = ent.blocked ? 16'd0 : ent.count;
    assign cnt1 = (cnt0 == COUNT_MAX) ? cnt0 : cnt0 + 16'd1;

    assign sweep_blk = ent.blocked && !ban_over;

    always_comb
    begin
        // Connection hit
        upd.conn_ent    = ent;
        upd.conn_write  = 1'b1;
        upd.conn_reject = 1'b0;
        if (ent.blocked && !ban_over)
        begin
            upd.conn_write  = 1'b0;
            upd.conn_reject = 1'b1;
        end
        else if (in_window)
        begin
            upd.conn_ent.blocked   = 1'b0;
            upd.conn_ent.count     = cnt1;
            upd.conn_ent.conn_time = now;
            if (cnt1 > cfg.limit)
            begin
                upd.conn_ent.blocked     = 1'b1;
                upd.conn_ent.last_reject = now;
                upd.conn_reject          = 1'b1;
            end
        end
        else
        begin
            upd.conn_ent.blocked   = 1'b0;
            upd.conn_ent.count     = 16'd1;
            upd.conn_ent.conn_time = now;
        end

        // Sweep
        upd.sweep_ent   = ent;
        upd.sweep_freed = 1'b0;
        if (ent.addr != 32'd0)
        begin
            upd.sweep_ent.blocked = sweep_blk;
            if (!sweep_blk && stale)
            begin
                upd.sweep_ent   = '0;
                upd.sweep_freed = 1'b1;
            end
        end
    end

endmodule

/* rtl/per_source_rate_limit_table.sv */
// Top level of the per-source connection rate limit table.
//
//  channel   direction  handshake             word
//  -------   ---------  --------------------  -----------------------------------
//  item      in         start && !busy        kind, source_addr, now_secs
//  result    out        done (one cycle)      reject, freed_count
//  config    in         cfg_we                cfg_index, cfg_data
//
//  States: a connection word runs through scan, drain and decide before done, a sweep
//  through scan and drain; the RAM is read one entry per cycle over its single read port.
//  Reset: after rst_n the table is zeroed by a clearing pass of TABLE_DEPTH cycles, with
//  busy high; config writes are taken during that pass.
//  Stalls: none on the result side; done is a one-cycle strobe. busy drops in the cycle
//  after the write-back, so a new word may be accepted while done is high.
module per_source_rate_limit_table
    import psrl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   kind,
    input  logic [31:0]            source_addr,
    input  logic [31:0]            now_secs,
    output logic                   done,
    output logic                   reject,
    output logic [6:0]             freed_count,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    // Table RAM, one packed entry per word
    entry_t mem [TABLE_DEPTH];

    state_t        state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    cfg_t          cfg_reg;

    // Latched item
    logic          kind_reg;
    logic [31:0]   addr_reg;
    logic [31:0]   now_reg;

    // Read pipeline
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data_reg;
    logic          rv_reg;
    logic [AW-1:0] ridx_reg;

    // Write port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    // Scan results
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    entry_t        hit_ent_reg;
    logic          empty_reg;
    logic [AW-1:0] empty_idx_reg;
    logic [AW-1:0] old_idx_reg;
    logic [31:0]   old_time_reg;
    logic [6:0]    freed_reg;
    logic [6:0]    freed_step;

    // Result
    logic          res_valid;
    logic          res_reject;
    logic [6:0]    res_freed;
    logic          done_reg;
    logic          reject_reg;
    logic [6:0]    freed_out_reg;

    entry_t        calc_ent;
    upd_t          upd;
    entry_t        fill_ent;
    logic          accept;
    logic          sweep_data;
    logic          conn_data;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign sweep_data = rv_reg && (kind_reg == KIND_SWEEP);
    assign conn_data  = rv_reg && (kind_reg == KIND_CONN);

    // During the decide cycle the stored hit entry is evaluated, else the word just read
    assign calc_ent = (state_reg == S_DECIDE) ? hit_ent_reg : rd_data_reg;

    psrl_entry_update u_update
    (
        .ent (calc_ent),
        .now (now_reg),
        .cfg (cfg_reg),
        .upd (upd)
    );

    assign fill_ent = '{addr: addr_reg, conn_time: now_reg, last_reject: 32'd0,
                        count: 16'd1, blocked: 1'b0};

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window <= DEF_WINDOW_SECS;
            cfg_reg.limit  <= DEF_RATE_LIMIT;
            cfg_reg.stale  <= DEF_STALE_SECS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW: cfg_reg.window <= cfg_data[15:0];
                REG_LIMIT:  cfg_reg.limit  <= cfg_data[15:0];
                REG_STALE:  cfg_reg.stale  <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = (kind_reg == KIND_SWEEP) ? S_IDLE : S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    // Saturating freed count including the word in flight
    assign freed_step = (sweep_data && upd.sweep_freed && freed_reg != FREED_MAX)
                        ? freed_reg + 7'd1 : freed_reg;

    // Outputs: RAM ports and result
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = ridx_reg;
        wr_data    = upd.sweep_ent;
        res_valid  = 1'b0;
        res_reject = 1'b0;
        res_freed  = 7'd0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = '0;
            end
            S_IDLE:
            begin
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
                wr_en = sweep_data;
            end
            S_DRAIN:
            begin
                wr_en = sweep_data;
                if (kind_reg == KIND_SWEEP)
                begin
                    res_valid = 1'b1;
                    res_freed = freed_step;
                end
            end
            S_DECIDE:
            begin
                res_valid = 1'b1;
                if (addr_reg != 32'd0)
                begin
                    if (hit_reg)
                    begin
                        wr_en      = upd.conn_write;
                        wr_addr    = hit_idx_reg;
                        wr_data    = upd.conn_ent;
                        res_reject = upd.conn_reject;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = empty_reg ? empty_idx_reg : old_idx_reg;
                        wr_data = fill_ent;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Table RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            ridx_reg  <= '0;
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
            freed_reg <= 7'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rv_reg    <= rd_en;
            ridx_reg  <= rd_addr;
            done_reg  <= res_valid;
            if (accept)
            begin
                hit_reg   <= 1'b0;
                empty_reg <= 1'b0;
                freed_reg <= 7'd0;
            end
            else
            begin
                freed_reg <= freed_step;
                // First match and first empty slot win
                if (conn_data && !hit_reg && rd_data_reg.addr == addr_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (conn_data && !empty_reg && rd_data_reg.addr == 32'd0)
                begin
                    empty_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            addr_reg <= source_addr;
            now_reg  <= now_secs;
        end
        if (conn_data)
        begin
            if (!hit_reg && rd_data_reg.addr == addr_reg)
            begin
                hit_idx_reg <= ridx_reg;
                hit_ent_reg <= rd_data_reg;
            end
            if (!empty_reg && rd_data_reg.addr == 32'd0)
            begin
                empty_idx_reg <= ridx_reg;
            end
            // Oldest last-connection time, lowest index on ties
            if (ridx_reg == '0 || rd_data_reg.conn_time < old_time_reg)
            begin
                old_idx_reg  <= ridx_reg;
                old_time_reg <= rd_data_reg.conn_time;
            end
        end
        if (res_valid)
        begin
            reject_reg    <= res_reject;
            freed_out_reg <= res_freed;
        end
    end

    assign done        = done_reg;
    assign reject      = reject_reg;
    assign freed_count = freed_out_reg;

`ifndef SYNTHESIS
    // The RAM is never written while the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table write while idle");

    // An accepted word makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    // One result per word: strobes never come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // A result never reports both a reject and freed entries
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(reject && freed_count != 7'd0))
        else $error("reject and freed count both set");

    // Read data is only consumed during a scan or its drain cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("read data outside a scan");
`endif

endmodule
